// ===== hw/rtl/clp_pkg.sv =====
// Shared types, character codes and the per-mode lexing function of the command line lexer.
// Used by clp_front, clp_fifo, clp_back and command_line_lexer; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

    // Lexer modes. Codes above MODE_WS are never entered and decode as waiting.
    typedef enum logic [2:0] {
        MODE_WAIT  = 3'd0,
        MODE_NAME  = 3'd1,
        MODE_UNQ   = 3'd2,
        MODE_QUOTE = 3'd3,
        MODE_WS    = 3'd4
    } mode_t;

    // Token kinds carried with a token end.
    localparam logic [2:0] KindName   = 3'd0;
    localparam logic [2:0] KindString = 3'd1;
    localparam logic [2:0] KindWs     = 3'd2;
    localparam logic [2:0] KindEol    = 3'd3;
    localparam logic [2:0] KindDollar = 3'd4;
    localparam logic [2:0] KindOpen   = 3'd5;
    localparam logic [2:0] KindClose  = 3'd6;
    localparam logic [2:0] KindEquals = 3'd7;

    // Characters with a meaning of their own.
    localparam logic [7:0] CharNul     = 8'h00;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharQuote   = 8'h22;
    localparam logic [7:0] CharDollar  = 8'h24;
    localparam logic [7:0] CharEquals  = 8'h3D;
    localparam logic [7:0] CharOpen    = 8'h7B;
    localparam logic [7:0] CharClose   = 8'h7D;

    // Depth of the queue between the front and back parts.
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       token_done;
        logic [2:0] token_kind;
    } res_t;

    // One input byte's worth of results: one or two.
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    typedef struct packed {
        logic  emit;
        res_t  res;
        logic  redo;
        mode_t next_mode;
    } step_t;

    function automatic logic is_line_end(logic [7:0] c);
        return (c == CharNul) || (c == CharNewline);
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return is_line_end(c) || (c == CharSpace) || (c == CharDollar) ||
               (c == CharOpen) || (c == CharClose) || (c == CharEquals);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic res_t mk_res(logic has, logic [7:0] c, logic done, logic [2:0] kind);
        res_t r;
        r.has_char   = has;
        r.out_char   = has ? c : 8'h00;
        r.token_done = done;
        r.token_kind = done ? kind : KindName;
        return r;
    endfunction

    // Handles one byte in the given mode. redo asks for the byte to be handled
    // again in the waiting mode.
    function automatic step_t lex_step(mode_t mode, logic [7:0] c);
        step_t s;
        s.emit      = 1'b0;
        s.res       = mk_res(1'b0, c, 1'b0, KindName);
        s.redo      = 1'b0;
        s.next_mode = mode;
        unique case (mode)
            MODE_NAME: begin
                if (is_letter(c) || is_digit(c)) begin
                    s.emit = 1'b1;
                    s.res  = mk_res(1'b1, c, 1'b0, KindName);
                end else if (is_special(c)) begin
                    s.next_mode = MODE_WAIT;
                    s.emit      = 1'b1;
                    s.res       = mk_res(1'b0, c, 1'b1, KindName);
                    s.redo      = 1'b1;
                end else if (c == CharQuote) begin
                    s.next_mode = MODE_QUOTE;
                end else begin
                    s.next_mode = MODE_UNQ;
                    s.emit      = 1'b1;
                    s.res       = mk_res(1'b1, c, 1'b0, KindName);
                end
            end
            MODE_UNQ: begin
                if (is_special(c)) begin
                    s.next_mode = MODE_WAIT;
                    s.emit      = 1'b1;
                    s.res       = mk_res(1'b0, c, 1'b1, KindString);
                    s.redo      = 1'b1;
                end else if (c == CharQuote) begin
                    s.next_mode = MODE_QUOTE;
                end else begin
                    s.emit = 1'b1;
                    s.res  = mk_res(1'b1, c, 1'b0, KindName);
                end
            end
            MODE_QUOTE: begin
                if (c == CharQuote) begin
                    s.next_mode = MODE_WAIT;
                    s.emit      = 1'b1;
                    s.res       = mk_res(1'b0, c, 1'b1, KindString);
                end else if (is_line_end(c)) begin
                    s.next_mode = MODE_WAIT;
                    s.emit      = 1'b1;
                    s.res       = mk_res(1'b0, c, 1'b1, KindString);
                    s.redo      = 1'b1;
                end else begin
                    s.emit = 1'b1;
                    s.res  = mk_res(1'b1, c, 1'b0, KindName);
                end
            end
            MODE_WS: begin
                s.emit = 1'b1;
                if (c == CharSpace) begin
                    s.res = mk_res(1'b1, c, 1'b0, KindName);
                end else if (is_line_end(c)) begin
                    s.next_mode = MODE_WAIT;
                    s.res       = mk_res(1'b1, c, 1'b1, KindEol);
                end else begin
                    s.next_mode = MODE_WAIT;
                    s.res       = mk_res(1'b0, c, 1'b1, KindWs);
                    s.redo      = 1'b1;
                end
            end
            default: begin
                s.next_mode = MODE_WAIT;
                s.emit      = 1'b1;
                if (is_line_end(c)) begin
                    s.res = mk_res(1'b1, c, 1'b1, KindEol);
                end else if (c == CharSpace) begin
                    s.next_mode = MODE_WS;
                    s.res       = mk_res(1'b1, c, 1'b0, KindName);
                end else if (c == CharDollar) begin
                    s.res = mk_res(1'b1, c, 1'b1, KindDollar);
                end else if (c == CharOpen) begin
                    s.res = mk_res(1'b1, c, 1'b1, KindOpen);
                end else if (c == CharClose) begin
                    s.res = mk_res(1'b1, c, 1'b1, KindClose);
                end else if (c == CharEquals) begin
                    s.res = mk_res(1'b1, c, 1'b1, KindEquals);
                end else if (c == CharQuote) begin
                    s.next_mode = MODE_QUOTE;
                    s.emit      = 1'b0;
                end else if (is_letter(c)) begin
                    s.next_mode = MODE_NAME;
                    s.res       = mk_res(1'b1, c, 1'b0, KindName);
                end else begin
                    s.next_mode = MODE_UNQ;
                    s.res       = mk_res(1'b1, c, 1'b0, KindName);
                end
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clp_front.sv =====
// Front part of the command line lexer: accepts bytes, keeps the lexer mode and
// forms the results, if any, of each byte: none, one or two. Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_in_byte,
    input  wire logic            queue_full,
    output logic                 push,
    output clp_pkg::entry_t      push_entry
);

    clp_pkg::mode_t mode_reg;
    clp_pkg::mode_t mode_next;
    clp_pkg::step_t first_step;
    clp_pkg::step_t second_step;
    logic           accept;
    logic           use_second;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        first_step  = clp_pkg::lex_step(mode_reg, s_in_byte);
        second_step = clp_pkg::lex_step(clp_pkg::MODE_WAIT, s_in_byte);
        use_second  = first_step.redo && second_step.emit;

        push_entry.two = first_step.emit && use_second;
        push_entry.r0  = first_step.emit ? first_step.res : second_step.res;
        push_entry.r1  = second_step.res;
        push           = accept && (first_step.emit || use_second);

        mode_next = first_step.redo ? second_step.next_mode : first_step.next_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= clp_pkg::MODE_WAIT;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

    // A token end that hands the byte back always leaves the mode at waiting first,
    // so a second result can only follow a first one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_entry.r0.has_char || push_entry.r0.token_done))
        else $error("clp_front: pushed an empty result");

endmodule

`default_nettype wire

// ===== hw/rtl/clp_fifo.sv =====
// Short queue of per-byte result entries between the front and back parts.
// Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire clp_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output clp_pkg::entry_t       head_entry,
    output logic                  empty,
    output logic                  full
);

    localparam logic [clp_pkg::QueueAw-1:0] LastSlot =
        clp_pkg::QueueAw'(clp_pkg::QueueDepth - 1);
    localparam logic [clp_pkg::QueueAw:0] DepthCount =
        (clp_pkg::QueueAw + 1)'(clp_pkg::QueueDepth);

    clp_pkg::entry_t                 mem [clp_pkg::QueueDepth];
    logic [clp_pkg::QueueAw-1:0]     wr_ptr_reg;
    logic [clp_pkg::QueueAw-1:0]     wr_ptr_next;
    logic [clp_pkg::QueueAw-1:0]     rd_ptr_reg;
    logic [clp_pkg::QueueAw-1:0]     rd_ptr_next;
    logic [clp_pkg::QueueAw:0]       count_reg;
    logic [clp_pkg::QueueAw:0]       count_next;
    logic                            do_push;
    logic                            do_pop;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == DepthCount);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("clp_fifo: push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("clp_fifo: pop from an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("clp_fifo: pointers disagree with an empty count");

endmodule

`default_nettype wire

// ===== hw/rtl/clp_back.sv =====
// Back part of the command line lexer: delivers the results of each queued
// entry one per transaction and marks the last one. Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire clp_pkg::entry_t  head_entry,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_has_char,
    output logic [7:0]            m_out_char,
    output logic                  m_token_done,
    output logic [2:0]            m_token_kind,
    output logic                  m_last_result
);

    logic          second_reg;
    logic          second_next;
    logic          m_accept;
    clp_pkg::res_t cur;

    assign m_valid       = !empty;
    assign m_accept      = m_valid && m_ready;
    assign cur           = second_reg ? head_entry.r1 : head_entry.r0;
    assign m_has_char    = cur.has_char;
    assign m_out_char    = cur.out_char;
    assign m_token_done  = cur.token_done;
    assign m_token_kind  = cur.token_kind;
    assign m_last_result = second_reg || !head_entry.two;
    assign pop           = m_accept && m_last_result;

    always_comb begin
        second_next = second_reg;
        if (m_accept) begin
            second_next = !m_last_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
        end
    end

    // The second result is only ever pending for an entry that holds two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> (m_valid && head_entry.two))
        else $error("clp_back: second result pending without a two-result entry");

endmodule

`default_nettype wire

// ===== hw/rtl/command_line_lexer.sv =====
// Each result is registered in the queue between front and back before it is offered.
// Throughput: one byte per cycle while the queue is not full; a byte that yields two
// results takes two output transactions, and the four-entry queue absorbs the difference.
// Bytes that yield no result pass through the front alone and use no queue slot.
// Reset (aresetn low, synchronous): lexer mode returns to waiting and the queue empties.
// Depends on clp_pkg, clp_front, clp_fifo and clp_back.
`timescale 1ns / 1ps
`default_nettype none

module command_line_lexer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_has_char,
    output logic [7:0]       m_out_char,
    output logic             m_token_done,
    output logic [2:0]       m_token_kind,
    output logic             m_last_result
);

    logic            push;
    logic            pop;
    logic            empty;
    logic            full;
    clp_pkg::entry_t push_entry;
    clp_pkg::entry_t head_entry;

    clp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    clp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (empty),
        .full       (full)
    );

    clp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_entry    (head_entry),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_has_char    (m_has_char),
        .m_out_char    (m_out_char),
        .m_token_done  (m_token_done),
        .m_token_kind  (m_token_kind),
        .m_last_result (m_last_result)
    );

endmodule

`default_nettype wire

// ===== tb/lexer_token_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of command_line_lexer, predicts its token output and compares.
// Depends on clp_pkg for the lexer modes, token kinds and character codes.

module lexer_token_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_has_char,
    input  logic [7:0] m_out_char,
    input  logic       m_token_done,
    input  logic [2:0] m_token_kind,
    input  logic       m_last_result,
    output int         mismatch_count,
    output int         expected_left
);

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       token_done;
        logic [2:0] token_kind;
        logic       last_result;
    } lex_out_t;

    clp_pkg::mode_t lex_mode;
    lex_out_t       expected_tokens[$];
    lex_out_t       byte_results[$];

    initial begin
        mismatch_count = 0;
        expected_left  = 0;
        lex_mode       = clp_pkg::MODE_WAIT;
    end

    task automatic report_error(input string msg);
        $display("[%0t] lexer check: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void put_out(logic has, logic [7:0] c, logic done, logic [2:0] kind);
        lex_out_t r;
        r.has_char    = has;
        r.out_char    = has ? c : 8'h00;
        r.token_done  = done;
        r.token_kind  = done ? kind : '0;
        r.last_result = 1'b0;
        byte_results.push_back(r);
    endfunction

    // Handles one byte in the current mode; returns 1 when the byte closed a
    // token and must be looked at again from the waiting mode.
    function automatic bit lex_in_mode(logic [7:0] c);
        bit eol   = (c == clp_pkg::CharNul) || (c == clp_pkg::CharNewline);
        bit term  = eol || (c inside {clp_pkg::CharSpace, clp_pkg::CharDollar,
                                      clp_pkg::CharOpen, clp_pkg::CharClose,
                                      clp_pkg::CharEquals});
        bit alpha = (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
        bit num   = c inside {[8'h30:8'h39]};
        case (lex_mode)
            clp_pkg::MODE_NAME: begin
                if (alpha || num) begin
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end else if (term) begin
                    lex_mode = clp_pkg::MODE_WAIT;
                    put_out(1'b0, c, 1'b1, clp_pkg::KindName);
                    return 1'b1;
                end else if (c == clp_pkg::CharQuote) begin
                    lex_mode = clp_pkg::MODE_QUOTE;
                end else begin
                    lex_mode = clp_pkg::MODE_UNQ;
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end
            end
            clp_pkg::MODE_UNQ: begin
                if (term) begin
                    lex_mode = clp_pkg::MODE_WAIT;
                    put_out(1'b0, c, 1'b1, clp_pkg::KindString);
                    return 1'b1;
                end else if (c == clp_pkg::CharQuote) begin
                    lex_mode = clp_pkg::MODE_QUOTE;
                end else begin
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end
            end
            clp_pkg::MODE_QUOTE: begin
                if (c == clp_pkg::CharQuote) begin
                    lex_mode = clp_pkg::MODE_WAIT;
                    put_out(1'b0, c, 1'b1, clp_pkg::KindString);
                end else if (eol) begin
                    lex_mode = clp_pkg::MODE_WAIT;
                    put_out(1'b0, c, 1'b1, clp_pkg::KindString);
                    return 1'b1;
                end else begin
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end
            end
            clp_pkg::MODE_WS: begin
                if (c == clp_pkg::CharSpace) begin
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end else begin
                    lex_mode = clp_pkg::MODE_WAIT;
                    if (eol) begin
                        put_out(1'b1, c, 1'b1, clp_pkg::KindEol);
                    end else begin
                        put_out(1'b0, c, 1'b1, clp_pkg::KindWs);
                        return 1'b1;
                    end
                end
            end
            default: begin
                lex_mode = clp_pkg::MODE_WAIT;
                if (eol) begin
                    put_out(1'b1, c, 1'b1, clp_pkg::KindEol);
                end else if (c == clp_pkg::CharSpace) begin
                    lex_mode = clp_pkg::MODE_WS;
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end else if (c == clp_pkg::CharDollar) begin
                    put_out(1'b1, c, 1'b1, clp_pkg::KindDollar);
                end else if (c == clp_pkg::CharOpen) begin
                    put_out(1'b1, c, 1'b1, clp_pkg::KindOpen);
                end else if (c == clp_pkg::CharClose) begin
                    put_out(1'b1, c, 1'b1, clp_pkg::KindClose);
                end else if (c == clp_pkg::CharEquals) begin
                    put_out(1'b1, c, 1'b1, clp_pkg::KindEquals);
                end else if (c == clp_pkg::CharQuote) begin
                    lex_mode = clp_pkg::MODE_QUOTE;
                end else if (alpha) begin
                    lex_mode = clp_pkg::MODE_NAME;
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end else begin
                    lex_mode = clp_pkg::MODE_UNQ;
                    put_out(1'b1, c, 1'b0, clp_pkg::KindName);
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        byte_results.delete();
        if (lex_in_mode(c)) begin
            lex_mode = clp_pkg::MODE_WAIT;
            void'(lex_in_mode(c));
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last_result = 1'b1;
        foreach (byte_results[i])
            expected_tokens.push_back(byte_results[i]);
    endfunction

    // Expectations are queued before the result side is checked, so a result
    // can never be compared ahead of its own byte.
    always @(posedge aclk) begin
        lex_out_t want;
        if (!aresetn) begin
            lex_mode = clp_pkg::MODE_WAIT;
            expected_tokens.delete();
        end else begin
            if (s_valid && s_ready)
                lex_byte(s_in_byte);
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_error("result transaction with no expectation pending");
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_has_char !== want.has_char)
                        report_error($sformatf("has_char %b, want %b", m_has_char, want.has_char));
                    if (m_out_char !== want.out_char)
                        report_error($sformatf("out_char %h, want %h", m_out_char, want.out_char));
                    if (m_token_done !== want.token_done)
                        report_error($sformatf("token_done %b, want %b",
                                               m_token_done, want.token_done));
                    if (m_token_kind !== want.token_kind)
                        report_error($sformatf("token_kind %0d, want %0d",
                                               m_token_kind, want.token_kind));
                    if (m_last_result !== want.last_result)
                        report_error($sformatf("last_result %b, want %b",
                                               m_last_result, want.last_result));
                end
            end
        end
        expected_left = expected_tokens.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the command_line_lexer testbench: clock, reset, byte stimulus and the verdict.
// Depends on clp_pkg, command_line_lexer and lexer_token_checker.

module tb_top;

    localparam int ItemCount  = 1450;
    localparam int QuietTail  = 150;
    localparam int PauseAt    = 700;
    localparam int StallLimit = 1000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_has_char;
    logic [7:0] m_out_char;
    logic       m_token_done;
    logic [2:0] m_token_kind;
    logic       m_last_result;
    int         mismatch_count;
    int         expected_left;

    bit         calm = 1'b0;
    int         idle_cycles = 0;
    logic [7:0] line_bytes[$];

    command_line_lexer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_has_char    (m_has_char),
        .m_out_char    (m_out_char),
        .m_token_done  (m_token_done),
        .m_token_kind  (m_token_kind),
        .m_last_result (m_last_result)
    );

    lexer_token_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_char     (m_has_char),
        .m_out_char     (m_out_char),
        .m_token_done   (m_token_done),
        .m_token_kind   (m_token_kind),
        .m_last_result  (m_last_result),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // The watchdog ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: ready drops in random bursts until the quiet tail of the run.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] letter_char();
        return 8'($urandom_range(0, 1) ? $urandom_range(8'h41, 8'h5A)
                                        : $urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    // A byte that neither ends a token nor opens a quote.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = any_char(); while (clp_pkg::is_special(b) || b == clp_pkg::CharQuote);
        return b;
    endfunction

    // Anything that may sit inside a quoted string without ending it.
    function automatic logic [7:0] quoted_char();
        logic [7:0] b;
        do b = any_char();
        while (b == clp_pkg::CharQuote || b == clp_pkg::CharNul || b == clp_pkg::CharNewline);
        return b;
    endfunction

    // One command line of random tokens, mostly well formed, ended by NUL or newline.
    function automatic void build_line();
        logic [7:0] specials[4] = '{clp_pkg::CharDollar, clp_pkg::CharOpen,
                                    clp_pkg::CharClose, clp_pkg::CharEquals};
        int         ntok;
        int         len;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            len = $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    line_bytes.push_back(letter_char());
                    repeat (len)
                        line_bytes.push_back($urandom_range(0, 7) == 0 ? any_char() :
                                             $urandom_range(0, 2) == 0 ? digit_char() :
                                             letter_char());
                end
                3: begin
                    line_bytes.push_back(plain_char());
                    repeat (len)
                        line_bytes.push_back($urandom_range(0, 1) ? plain_char() : letter_char());
                end
                4: begin
                    line_bytes.push_back(clp_pkg::CharQuote);
                    repeat (len) line_bytes.push_back(quoted_char());
                    if ($urandom_range(0, 4) != 0)
                        line_bytes.push_back(clp_pkg::CharQuote);
                end
                5: repeat ($urandom_range(1, 4)) line_bytes.push_back(clp_pkg::CharSpace);
                6, 7: line_bytes.push_back(specials[$urandom_range(0, 3)]);
                8: line_bytes.push_back(any_char());
                default: begin
                    // A name that runs into a quote and finishes as a string.
                    line_bytes.push_back(letter_char());
                    line_bytes.push_back(clp_pkg::CharQuote);
                    repeat (len) line_bytes.push_back(quoted_char());
                    line_bytes.push_back(clp_pkg::CharQuote);
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                line_bytes.push_back(clp_pkg::CharSpace);
        end
        line_bytes.push_back($urandom_range(0, 1) ? clp_pkg::CharNewline : clp_pkg::CharNul);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_left != 0);
    endtask

    initial begin
        logic [7:0] directed[] = '{
            8'h41, 8'h62, 8'h39, clp_pkg::CharEquals,         // name closed by equals
            8'h78, 8'h2D, clp_pkg::CharSpace,                 // name turns unquoted
            clp_pkg::CharSpace,                               // then spaces
            clp_pkg::CharNewline,                             // line end after whitespace
            clp_pkg::CharSpace, clp_pkg::CharDollar,          // whitespace closed by dollar
            clp_pkg::CharOpen, clp_pkg::CharClose,
            8'h61, clp_pkg::CharQuote, 8'h62,                 // quote opened inside a name
            clp_pkg::CharQuote,
            8'h37, clp_pkg::CharQuote, 8'h71,                 // line end inside quotes
            clp_pkg::CharNewline,
            clp_pkg::CharQuote, 8'hFF, 8'h80, clp_pkg::CharNul // NUL ends a quoted string
        };
        int sent;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'h00;
        sent      = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            send_byte(directed[i]);
            sent++;
        end

        while (sent < ItemCount) begin
            build_line();
            while (line_bytes.size() > 0) begin
                send_byte(line_bytes.pop_front());
                sent++;
                if (sent == PauseAt)
                    drain_results();
                if (sent >= ItemCount - QuietTail)
                    calm = 1'b1;
            end
        end

        drain_results();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && expected_left == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
